// File: hw/rtl/cms_pkg.sv
// Package for the count-min sketch table core: operation codes and field widths.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

    // Width of one column field of an input item, and number of such fields.
    localparam int COL_FIELD_W   = 10;
    localparam int COLUMN_FIELDS = 4;

    // Width of the query result.
    localparam int RESULT_W = 32;

    // Operation codes carried in the op field.
    localparam logic OP_INCREMENT = 1'b0;
    localparam logic OP_QUERY     = 1'b1;

endpackage : cms_pkg

`default_nettype wire

// File: hw/rtl/cms_if.sv
// Valid/ready channel interfaces of the count-min sketch table core.
// Depends on cms_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface cms_item_if;
    import cms_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [COL_FIELD_W-1:0] row0_column;
    logic [COL_FIELD_W-1:0] row1_column;
    logic [COL_FIELD_W-1:0] row2_column;
    logic [COL_FIELD_W-1:0] row3_column;

    modport source (
        output valid, op, row0_column, row1_column, row2_column, row3_column,
        input  ready
    );
    modport sink (
        input  valid, op, row0_column, row1_column, row2_column, row3_column,
        output ready
    );
endinterface : cms_item_if

interface cms_result_if;
    import cms_pkg::*;

    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] min_count;

    modport source (
        output valid, min_count,
        input  ready
    );
    modport sink (
        input  valid, min_count,
        output ready
    );
endinterface : cms_result_if

`default_nettype wire

// File: hw/rtl/count_min_sketch_table_core.sv
// Count-min sketch table core: one counter memory bank per row, read-modify-write.
// Depends on cms_pkg and the channel interfaces in cms_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                         Transfer
// item      in   op, row0_column .. row3_column                  valid & ready
// result    out  min_count (one per query, none per increment)   valid & ready
//
// For each item, the accepting edge reads one counter from every row bank, and
// the edge that ends the busy state writes the incremented counters back or
// loads the minimum into the result register. The banks have a single port
// each, so the read and the write-back of one item cannot share a cycle.
// After reset a clearing pass writes zero to every column of all banks at once;
// no item is accepted during it.
// A query whose result register is still occupied waits in the busy state
// until the previous result transfers; increments never wait on the output.

module count_min_sketch_table_core #(
    parameter int COLUMNS      = 1024,
    parameter int ROWS         = 4,
    parameter int COUNTER_BITS = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    cms_item_if.sink     item,
    cms_result_if.source result
);
    import cms_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef logic [COL_W-1:0]        col_t;
    typedef logic [COUNTER_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    // Reduce a column field modulo COLUMNS by restoring subtraction of the
    // shifted column count; steps whose shifted count exceeds the field's
    // range are constant false and drop out.
    function automatic col_t col_wrap(input logic [COL_FIELD_W-1:0] field);
        logic [31:0] r;
        r = 32'(field);
        for (int k = COL_FIELD_W - 1; k >= 0; k--)
        begin
            if ((64'(COLUMNS) << k) <= 64'(r))
            begin
                r = r - 32'(64'(COLUMNS) << k);
            end
        end
        return col_t'(r);
    endfunction

    state_t                state_reg, state_next;
    col_t                  clr_idx_reg, clr_idx_next;
    logic                  op_reg, op_next;
    col_t                  col_reg [ROWS];
    col_t                  col_next [ROWS];
    logic                  out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]   min_count_reg, min_count_next;

    count_t                rd_data_reg [ROWS];
    col_t                  item_col [ROWS];
    logic [COL_FIELD_W-1:0] fields [COLUMN_FIELDS];

    logic                  accept;
    logic                  wr_en;
    col_t                  wr_addr [ROWS];
    count_t                wr_data [ROWS];
    count_t                least;

    assign fields[0] = item.row0_column;
    assign fields[1] = item.row1_column;
    assign fields[2] = item.row2_column;
    assign fields[3] = item.row3_column;

    // Rows past the last column field address column zero.
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            if (r < COLUMN_FIELDS)
            begin
                item_col[r] = col_wrap(fields[r]);
            end
            else
            begin
                item_col[r] = '0;
            end
        end
    end

    assign item.ready    = (state_reg == ST_IDLE);
    assign accept        = item.valid && item.ready;
    assign result.valid     = out_valid_reg;
    assign result.min_count = min_count_reg;

    // Minimum over the counters read for the current item.
    always_comb
    begin
        least = '1;
        for (int r = 0; r < ROWS; r++)
        begin
            if (rd_data_reg[r] < least)
            begin
                least = rd_data_reg[r];
            end
        end
    end

    // Write port: zero during the clearing pass, saturating increment otherwise.
    always_comb
    begin
        wr_en = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_BUSY && op_reg == OP_INCREMENT)
        begin
            wr_en = 1'b1;
        end
        for (int r = 0; r < ROWS; r++)
        begin
            if (state_reg == ST_CLEAR)
            begin
                wr_addr[r] = clr_idx_reg;
                wr_data[r] = '0;
            end
            else
            begin
                wr_addr[r] = col_reg[r];
                if (rd_data_reg[r] == '1)
                begin
                    wr_data[r] = rd_data_reg[r];
                end
                else
                begin
                    wr_data[r] = rd_data_reg[r] + count_t'(1);
                end
            end
        end
    end

    // Next-state logic for the sequencer and the result register.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        min_count_next = min_count_reg;
        for (int r = 0; r < ROWS; r++)
        begin
            col_next[r] = col_reg[r];
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + col_t'(1);
                if (clr_idx_reg == col_t'(COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = item.op;
                    state_next = ST_BUSY;
                    for (int r = 0; r < ROWS; r++)
                    begin
                        col_next[r] = item_col[r];
                    end
                end
            end
            ST_BUSY:
            begin
                if (op_reg == OP_INCREMENT)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    min_count_next = RESULT_W'(least);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        min_count_reg <= min_count_next;
        for (int r = 0; r < ROWS; r++)
        begin
            col_reg[r] <= col_next[r];
        end
    end

    // One single-port bank per row; the read data register holds the counter
    // of the accepted item until its write-back or query is done.
    for (genvar g = 0; g < ROWS; g++)
    begin : g_bank
        count_t bank_mem [COLUMNS];

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bank_mem[wr_addr[g]] <= wr_data[g];
            end
            else if (accept)
            begin
                rd_data_reg[g] <= bank_mem[item_col[g]];
            end
        end
    end

endmodule : count_min_sketch_table_core

`default_nettype wire

// File: hw/rtl/cms_checker.sv
// Port-level checks for the count-min sketch table core, bound to its top level.
// Depends on count_min_sketch_table_core and cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cms_checker (
    input wire clk,
    input wire rst_n,
    input wire item_valid,
    input wire item_ready,
    input wire item_op,
    input wire result_valid,
    input wire result_ready
);
    import cms_pkg::*;

    // A result held back by the sink stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped before its transfer");

    // The core works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in progress");

    // An increment produces no result.
    a_incr_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_op == OP_INCREMENT |=> !$rose(result_valid))
        else $error("result appeared after an increment");

    // A result appears only as an item in progress finishes, so the edge
    // before it never offers ready on the item channel.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without a query in progress");

endmodule : cms_checker

bind count_min_sketch_table_core cms_checker u_cms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.op),
    .result_valid (result.valid),
    .result_ready (result.ready)
);

`default_nettype wire

// File: tb/count_min_sketch_table_core_tb.sv
// Self-checking testbench for the count-min sketch table core (4 rows x 1024 counters).
// Depends on cms_pkg, the channel interfaces in cms_if.sv and count_min_sketch_table_core.
`timescale 1ns / 1ps

module count_min_sketch_table_core_tb;
    import cms_pkg::*;

    localparam int COLUMNS      = 1024;
    localparam int ROWS         = 4;
    localparam int COUNTER_BITS = 32;

    // Number of frequently used columns per row in the random part. Reusing a
    // few columns lets counters climb well above one, so that queries return
    // more than zero and the minimum is taken over counters of different sizes.
    localparam int HOT_COLUMNS = 6;

    // One item as it waits in the driver's queue. The pause flag makes the
    // driver hold this item back until every outstanding query has answered.
    typedef struct packed {
        logic                                      op;
        logic [COLUMN_FIELDS-1:0][COL_FIELD_W-1:0] cols;
        logic                                      pause_before;
    } sketch_item_t;

    // Patterns of the result receiver. It switches between them at random,
    // so stalls hit both the read cycle and the write-back cycle.
    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY
    } ready_mode_e;

    logic clk;
    logic rst_n;

    cms_item_if   item_ch ();
    cms_result_if result_ch ();

    count_min_sketch_table_core #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .COUNTER_BITS (COUNTER_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predicted contents of the counter banks, kept in step with every
    // accepted item.
    logic [COUNTER_BITS-1:0] sketch_counts [ROWS][COLUMNS];

    // Minimum counts that the block still owes, oldest first.
    logic [RESULT_W-1:0] expected_min_counts [$];

    sketch_item_t pending_items [$];
    int           hot_cols [COLUMN_FIELDS][HOT_COLUMNS];
    int           error_count = 0;

    // Set by the monitor at a rising edge on which an item transfer took place,
    // and read by the driver at the falling edge that follows.
    logic item_taken = 1'b0;

    int          burst_left = 1;
    int          gap_left   = 0;
    ready_mode_e ready_mode = READY_ALWAYS;
    int          ready_left = 0;

    // The clock runs with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The limit is far above the slowest legal run, which is made up of the
    // clearing pass after reset and about 520 items.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Applies one accepted item to the predicted banks. An increment bumps the
    // addressed counter of every row and saturates at the all-ones value. A
    // query leaves the banks alone and queues the smallest addressed counter.
    // Rows beyond the input fields address column zero, and columns wrap at
    // the bank depth.
    function automatic void apply_sketch_item(input sketch_item_t it);
        logic [COUNTER_BITS-1:0] least;
        logic [COUNTER_BITS-1:0] value;
        int                      row;
        int                      col;
        least = '1;
        for (row = 0; row < ROWS; row++)
        begin
            col   = (row < COLUMN_FIELDS) ? int'(it.cols[row]) : 0;
            col   = col % COLUMNS;
            value = sketch_counts[row][col];
            if (it.op == OP_INCREMENT)
            begin
                if (value != '1)
                    sketch_counts[row][col] = value + 1'b1;
            end
            else if (value < least)
            begin
                least = value;
            end
        end
        if (it.op == OP_QUERY)
            expected_min_counts.push_back(RESULT_W'(least));
    endfunction

    function automatic void queue_item(input logic op, input int c0, input int c1,
                                       input int c2, input int c3, input logic pause);
        sketch_item_t it;
        it.op           = op;
        it.cols[0]      = c0[COL_FIELD_W-1:0];
        it.cols[1]      = c1[COL_FIELD_W-1:0];
        it.cols[2]      = c2[COL_FIELD_W-1:0];
        it.cols[3]      = c3[COL_FIELD_W-1:0];
        it.pause_before = pause;
        pending_items.push_back(it);
    endfunction

    // Most columns come from a small per-row set; the rest are uniform over
    // the whole field so that every column bit takes both values.
    function automatic int pick_column(input int row);
        if ($urandom_range(0, 9) < 7)
            return hot_cols[row][$urandom_range(0, HOT_COLUMNS - 1)];
        return $urandom_range(0, (1 << COL_FIELD_W) - 1);
    endfunction

    // Item driver. A new item is presented at a falling edge only once the
    // previous one has transferred. The sender works in bursts of random length
    // separated by random gaps; a gap of zero gives back-to-back items, which
    // is where an increment is immediately followed by a read of the same
    // counters.
    always @(negedge clk)
    begin : drive_items
        sketch_item_t next_item;
        if (rst_n && (!item_ch.valid || item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0 &&
                     !(pending_items[0].pause_before && expected_min_counts.size() != 0))
            begin
                next_item = pending_items.pop_front();
                item_ch.valid       <= 1'b1;
                item_ch.op          <= next_item.op;
                item_ch.row0_column <= next_item.cols[0];
                item_ch.row1_column <= next_item.cols[1];
                item_ch.row2_column <= next_item.cols[2];
                item_ch.row3_column <= next_item.cols[3];
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 8);
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready follows a pattern that changes at random, from
    // always ready through mostly ready to long stretches of stall.
    always @(negedge clk)
    begin : drive_result_ready
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_e'($urandom_range(0, 2));
            ready_left = $urandom_range(16, 96);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            READY_ALWAYS: result_ch.ready <= 1'b1;
            READY_MOSTLY: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default:      result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Monitor. Both channels are sampled at the rising edge, before the block's
    // own updates of that edge take effect. Every item transfer updates the
    // predicted banks; every result transfer is compared with the oldest
    // outstanding query.
    always @(posedge clk)
    begin : watch_channels
        sketch_item_t seen;
        logic [RESULT_W-1:0] want;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                seen.op           = item_ch.op;
                seen.cols[0]      = item_ch.row0_column;
                seen.cols[1]      = item_ch.row1_column;
                seen.cols[2]      = item_ch.row2_column;
                seen.cols[3]      = item_ch.row3_column;
                seen.pause_before = 1'b0;
                apply_sketch_item(seen);
                item_taken <= 1'b1;
            end
            else
            begin
                item_taken <= 1'b0;
            end

            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_min_counts.size() == 0)
                begin
                    $error("min_count: no query outstanding, got %0d", result_ch.min_count);
                    error_count++;
                end
                else
                begin
                    want = expected_min_counts.pop_front();
                    if (result_ch.min_count !== want)
                    begin
                        $error("min_count: expected %0d, got %0d", want, result_ch.min_count);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus and end of the run.
    initial
    begin : run_test
        int  n;
        int  row;
        int  hot;
        int  pause_at;
        int  c [COLUMN_FIELDS];
        logic pause;

        // Every input of the block starts from a known value.
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.op          = OP_INCREMENT;
        item_ch.row0_column = '0;
        item_ch.row1_column = '0;
        item_ch.row2_column = '0;
        item_ch.row3_column = '0;
        result_ch.ready     = 1'b0;

        for (row = 0; row < ROWS; row++)
            for (n = 0; n < COLUMNS; n++)
                sketch_counts[row][n] = '0;

        // The lowest and highest columns are always among the hot columns.
        for (row = 0; row < COLUMN_FIELDS; row++)
        begin
            hot_cols[row][0] = 0;
            hot_cols[row][1] = (1 << COL_FIELD_W) - 1;
            for (hot = 2; hot < HOT_COLUMNS; hot++)
                hot_cols[row][hot] = $urandom_range(0, (1 << COL_FIELD_W) - 1);
        end

        // Directed part. Queries on a freshly cleared table must return zero
        // at both ends of the column range.
        queue_item(OP_QUERY,     0,    0,    0,    0,    1'b0);
        queue_item(OP_QUERY,     1023, 1023, 1023, 1023, 1'b0);
        // Repeated increments of the same counters, read straight back.
        queue_item(OP_INCREMENT, 0,    0,    0,    0,    1'b0);
        queue_item(OP_INCREMENT, 0,    0,    0,    0,    1'b0);
        queue_item(OP_QUERY,     0,    0,    0,    0,    1'b0);
        queue_item(OP_INCREMENT, 1023, 1023, 1023, 1023, 1'b0);
        queue_item(OP_QUERY,     1023, 1023, 1023, 1023, 1'b0);
        // Alternating bit patterns in the column fields.
        queue_item(OP_INCREMENT, 'h155, 'h2AA, 'h155, 'h2AA, 1'b0);
        queue_item(OP_INCREMENT, 'h2AA, 'h155, 'h2AA, 'h155, 1'b0);
        queue_item(OP_QUERY,     'h155, 'h2AA, 'h155, 'h2AA, 1'b0);
        // The minimum taken from each row in turn.
        queue_item(OP_QUERY,     5,    0,    0,    0,    1'b0);
        queue_item(OP_QUERY,     0,    5,    0,    0,    1'b0);
        queue_item(OP_QUERY,     0,    0,    5,    0,    1'b0);
        queue_item(OP_QUERY,     0,    0,    0,    5,    1'b0);
        queue_item(OP_QUERY,     0,    1023, 'h155, 'h2AA, 1'b0);
        // One row shared across increments while the other rows move, so that
        // the rows hold different counts for the same item.
        queue_item(OP_INCREMENT, 7,    1,    2,    3,    1'b0);
        queue_item(OP_INCREMENT, 7,    4,    5,    6,    1'b0);
        queue_item(OP_INCREMENT, 7,    1,    5,    9,    1'b0);
        queue_item(OP_QUERY,     7,    1,    5,    9,    1'b0);
        queue_item(OP_QUERY,     7,    1,    5,    3,    1'b0);
        queue_item(OP_QUERY,     7,    8,    8,    8,    1'b0);

        // Random part. About one item in five starts an increment that is
        // followed at once by a query of the same columns; the rest are single
        // items, mostly on hot columns. Twice the sender holds back until the
        // block has answered every outstanding query.
        n        = 0;
        pause_at = 200;
        while (n < 500)
        begin
            pause = (n >= pause_at);
            if (pause)
                pause_at += 200;
            for (row = 0; row < COLUMN_FIELDS; row++)
                c[row] = pick_column(row);
            if ($urandom_range(0, 4) == 0)
            begin
                queue_item(OP_INCREMENT, c[0], c[1], c[2], c[3], pause);
                queue_item(OP_QUERY,     c[0], c[1], c[2], c[3], 1'b0);
                n += 2;
            end
            else
            begin
                queue_item(($urandom_range(0, 9) < 4) ? OP_QUERY : OP_INCREMENT,
                           c[0], c[1], c[2], c[3], pause);
                n += 1;
            end
        end

        // Reset is held low from the start and released at a falling edge. The
        // block then clears its banks before it accepts the first item; the
        // driver simply waits on ready through that pass.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (expected_min_counts.size() != 0)
            @(posedge clk);
        // The closing wait lets any stray result show up before the verdict.
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : count_min_sketch_table_core_tb
